FILE: design/d2q9_pkg.sv
// shared types, constants and fixed-point helpers of the d2q9 collide and stream cell
`timescale 1ns / 1ps

package d2q9_pkg;

  localparam int FRAC_BITS    = 28;
  localparam int MAX_GRID_DIM = 1024;
  localparam int NDIR         = 9;

  localparam int DIV_STEPS = 4;
  localparam int DIV_ITERS = 32 / DIV_STEPS;

  localparam logic [3:0] DIR_LAST = 4'(NDIR - 1);

  localparam logic [1:0] CFG_OMEGA  = 2'd0;
  localparam logic [1:0] CFG_GRID_W = 2'd1;
  localparam logic [1:0] CFG_GRID_H = 2'd2;

  typedef logic signed [31:0] val_t;

  localparam val_t VAL_MAX = 32'sh7fffffff;
  localparam val_t VAL_MIN = 32'sh80000000;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam longint W_REST = (4 * ONE_L + 4) / 9;
  localparam longint W_AXIS = (ONE_L + 4) / 9;
  localparam longint W_DIAG = (ONE_L + 18) / 36;
  localparam val_t ONE_Q = (FRAC_BITS >= 31) ? VAL_MAX : val_t'(32'(ONE_L));

  typedef struct packed {
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic [8:0] solid_mask;
    val_t       dist_rest;
    val_t       dist_east;
    val_t       dist_north;
    val_t       dist_west;
    val_t       dist_south;
    val_t       dist_northeast;
    val_t       dist_northwest;
    val_t       dist_southwest;
    val_t       dist_southeast;
  } cell_t;

  typedef struct packed {
    logic [9:0]  dest_x;
    logic [9:0]  dest_y;
    logic [3:0]  dest_dir;
    val_t        post_value;
    val_t        density;
    val_t        vel_x;
    val_t        vel_y;
    logic [30:0] speed_sq;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [9:0]            x;
    logic [9:0]            y;
    logic [8:0]            mask;
    val_t [NDIR-1:0]       f;
  } base_t;

  typedef struct packed {
    base_t       base;
    val_t        rho;
    val_t        vx;
    val_t        vy;
    logic [30:0] sq;
  } rec_t;

  typedef struct packed {
    logic [29:0] omega;
    logic [10:0] grid_w;
    logic [10:0] grid_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0][34:0] num;
    logic [1:0]       neg;
    logic [34:0]      den;
    logic             zero;
  } div_in_t;

  typedef struct packed {
    logic       done;
    val_t [1:0] vel;
  } div_out_t;

  function automatic val_t sat32(input logic signed [39:0] v);
    val_t r;
    if (v > 40'sd2147483647) r = VAL_MAX;
    else if (v < -40'sd2147483648) r = VAL_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic val_t mulq(input val_t a, input val_t b);
    logic signed [63:0] p;
    logic [63:0]        m;
    val_t               r;
    p = 64'(a) * 64'(b);
    m = p[63] ? 64'(-p) : 64'(p);
    m = m >> FRAC_BITS;
    if (p[63]) r = (m > 64'd2147483648) ? VAL_MIN : val_t'(32'(-m));
    else r = (m > 64'd2147483647) ? VAL_MAX : val_t'(32'(m));
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dx(input logic [3:0] q);
    logic signed [1:0] r;
    case (q)
      4'd1, 4'd5, 4'd8: r = 2'sd1;
      4'd3, 4'd6, 4'd7: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [3:0] q);
    logic signed [1:0] r;
    case (q)
      4'd2, 4'd5, 4'd6: r = 2'sd1;
      4'd4, 4'd7, 4'd8: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dir_opp(input logic [3:0] q);
    logic [3:0] r;
    case (q)
      4'd1: r = 4'd3;
      4'd2: r = 4'd4;
      4'd3: r = 4'd1;
      4'd4: r = 4'd2;
      4'd5: r = 4'd7;
      4'd6: r = 4'd8;
      4'd7: r = 4'd5;
      4'd8: r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic val_t weight(input logic [3:0] q);
    val_t r;
    case (q)
      4'd0: r = val_t'(32'(W_REST));
      4'd1, 4'd2, 4'd3, 4'd4: r = val_t'(32'(W_AXIS));
      default: r = val_t'(32'(W_DIAG));
    endcase
    return r;
  endfunction

endpackage

FILE: design/d2q9_if.sv
// valid/ready channels for cell beats and result beats
`timescale 1ns / 1ps

interface d2q9_cell_if import d2q9_pkg::*; ();
  logic  valid;
  logic  ready;
  cell_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface d2q9_res_if import d2q9_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/d2q9_div.sv
// iterative two-lane restoring divider for the cell velocity
`timescale 1ns / 1ps

module d2q9_div import d2q9_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  div_in_t  in_i,
  output div_out_t out_o
);

  localparam int NW = 35 + FRAC_BITS;
  localparam int CW = $clog2(DIV_ITERS + 1);

  logic             run_q, run_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [34:0]      den_q, den_d;
  logic             zero_q, zero_d;
  logic [1:0]       neg_q, neg_d;
  logic [1:0]       ovf_q, ovf_d;
  logic [1:0][35:0] p_q, p_d;
  logic [1:0][31:0] n_q, n_d;
  logic [1:0][31:0] quo_q, quo_d;

  always_comb begin
    logic [NW-1:0] nfull;
    logic [NW-1:0] hi;
    logic [35:0]   pt;
    logic          ge;
    run_d  = run_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    zero_d = zero_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    p_d    = p_q;
    n_d    = n_q;
    quo_d  = quo_q;
    nfull  = '0;
    hi     = '0;
    pt     = '0;
    ge     = 1'b0;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      den_d  = in_i.den;
      zero_d = in_i.zero;
      neg_d  = in_i.neg;
      for (int l = 0; l < 2; l++) begin
        nfull    = {in_i.num[l], {FRAC_BITS{1'b0}}};
        hi       = nfull >> 32;
        ovf_d[l] = hi >= NW'(in_i.den);
        p_d[l]   = 36'(hi);
        n_d[l]   = nfull[31:0];
        quo_d[l] = '0;
      end
    end else if (run_q && cnt_q != CW'(DIV_ITERS)) begin
      cnt_d = cnt_q + CW'(1);
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
          pt       = {p_d[l][34:0], n_d[l][31]};
          n_d[l]   = {n_d[l][30:0], 1'b0};
          ge       = pt >= {1'b0, den_q};
          p_d[l]   = ge ? pt - {1'b0, den_q} : pt;
          quo_d[l] = {quo_d[l][30:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    zero_q <= zero_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    p_q    <= p_d;
    n_q    <= n_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    out_o.done = run_q && cnt_q == CW'(DIV_ITERS);
    for (int l = 0; l < 2; l++) begin
      if (zero_q) out_o.vel[l] = '0;
      else if (ovf_q[l] || quo_q[l][31]) out_o.vel[l] = neg_q[l] ? VAL_MIN : VAL_MAX;
      else out_o.vel[l] = neg_q[l] ? -val_t'(quo_q[l]) : val_t'(quo_q[l]);
    end
  end

endmodule

FILE: design/d2q9_front.sv
// front part: takes cell beats, forms density, momentum, velocity and squared speed
`timescale 1ns / 1ps

module d2q9_front import d2q9_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  d2q9_cell_if.sink      cell_i,
  output logic           rec_valid_o,
  input  logic           rec_ready_i,
  output rec_t           rec_o
);

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;
  logic a_free, b_free, c_free, d_free, e_free, f_free;

  base_t a_base_q, b_base_q, c_base_q, d_base_q, e_base_q, f_base_q;
  base_t in_base;

  logic signed [33:0] a_r0_q, a_r1_q, a_r2_q, a_mxa_q, a_mxb_q, a_mya_q, a_myb_q;
  logic signed [35:0] b_rho_q, b_mx_q, b_my_q;
  div_in_t            c_div_q;
  val_t               c_rho_q, d_rho_q, e_rho_q, f_rho_q;
  val_t               e_vx_q, e_vy_q, f_vx_q, f_vy_q, f_sqx_q, f_sqy_q;
  div_out_t           div_out;
  logic [32:0]        sq_sum;

  always_comb begin
    in_base.x    = cell_i.data.cell_x;
    in_base.y    = cell_i.data.cell_y;
    in_base.mask = cell_i.data.solid_mask;
    in_base.f[0] = cell_i.data.dist_rest;
    in_base.f[1] = cell_i.data.dist_east;
    in_base.f[2] = cell_i.data.dist_north;
    in_base.f[3] = cell_i.data.dist_west;
    in_base.f[4] = cell_i.data.dist_south;
    in_base.f[5] = cell_i.data.dist_northeast;
    in_base.f[6] = cell_i.data.dist_northwest;
    in_base.f[7] = cell_i.data.dist_southwest;
    in_base.f[8] = cell_i.data.dist_southeast;
  end

  assign f_free = !f_v_q || rec_ready_i;
  assign e_free = !e_v_q || f_free;
  assign d_free = !d_v_q || (div_out.done && e_free);
  assign c_free = !c_v_q || d_free;
  assign b_free = !b_v_q || c_free;
  assign a_free = !a_v_q || b_free;
  assign cell_i.ready = a_free;

  d2q9_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(d_free && c_v_q),
    .in_i   (c_div_q),
    .out_o  (div_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      if (a_free) a_v_q <= cell_i.valid;
      if (b_free) b_v_q <= a_v_q;
      if (c_free) c_v_q <= b_v_q;
      if (d_free) d_v_q <= c_v_q;
      if (e_free) e_v_q <= d_v_q && div_out.done;
      if (f_free) f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_base_q <= in_base;
      a_r0_q   <= 34'(in_base.f[0]) + 34'(in_base.f[1]) + 34'(in_base.f[2]);
      a_r1_q   <= 34'(in_base.f[3]) + 34'(in_base.f[4]) + 34'(in_base.f[5]);
      a_r2_q   <= 34'(in_base.f[6]) + 34'(in_base.f[7]) + 34'(in_base.f[8]);
      a_mxa_q  <= 34'(in_base.f[1]) + 34'(in_base.f[5]) + 34'(in_base.f[8]);
      a_mxb_q  <= 34'(in_base.f[3]) + 34'(in_base.f[6]) + 34'(in_base.f[7]);
      a_mya_q  <= 34'(in_base.f[2]) + 34'(in_base.f[5]) + 34'(in_base.f[6]);
      a_myb_q  <= 34'(in_base.f[4]) + 34'(in_base.f[7]) + 34'(in_base.f[8]);
    end
    if (b_free) begin
      b_base_q <= a_base_q;
      b_rho_q  <= 36'(a_r0_q) + 36'(a_r1_q) + 36'(a_r2_q);
      b_mx_q   <= 36'(a_mxa_q) - 36'(a_mxb_q);
      b_my_q   <= 36'(a_mya_q) - 36'(a_myb_q);
    end
    if (c_free) begin
      c_base_q       <= b_base_q;
      c_rho_q        <= sat32(40'(b_rho_q));
      c_div_q.den    <= b_rho_q[35] ? 35'(-b_rho_q) : 35'(b_rho_q);
      c_div_q.zero   <= b_rho_q == '0;
      c_div_q.num[0] <= b_mx_q[35] ? 35'(-b_mx_q) : 35'(b_mx_q);
      c_div_q.num[1] <= b_my_q[35] ? 35'(-b_my_q) : 35'(b_my_q);
      c_div_q.neg[0] <= b_mx_q[35] ^ b_rho_q[35];
      c_div_q.neg[1] <= b_my_q[35] ^ b_rho_q[35];
    end
    if (d_free) begin
      d_base_q <= c_base_q;
      d_rho_q  <= c_rho_q;
    end
    if (e_free) begin
      e_base_q <= d_base_q;
      e_rho_q  <= d_base_q.mask[0] ? ONE_Q : d_rho_q;
      e_vx_q   <= d_base_q.mask[0] ? '0 : div_out.vel[0];
      e_vy_q   <= d_base_q.mask[0] ? '0 : div_out.vel[1];
    end
    if (f_free) begin
      f_base_q <= e_base_q;
      f_rho_q  <= e_rho_q;
      f_vx_q   <= e_vx_q;
      f_vy_q   <= e_vy_q;
      f_sqx_q  <= mulq(e_vx_q, e_vx_q);
      f_sqy_q  <= mulq(e_vy_q, e_vy_q);
    end
  end

  // squares are never negative, so only the upper bound can be hit
  assign sq_sum = 33'(f_sqx_q) + 33'(f_sqy_q);

  always_comb begin
    rec_valid_o = f_v_q;
    rec_o.base  = f_base_q;
    rec_o.rho   = f_rho_q;
    rec_o.vx    = f_vx_q;
    rec_o.vy    = f_vy_q;
    rec_o.sq    = sq_sum[32:31] != 2'b00 ? 31'h7fffffff : sq_sum[30:0];
  end

endmodule

FILE: design/d2q9_fifo.sv
// short queue of cell records between the front and back parts
`timescale 1ns / 1ps

module d2q9_fifo import d2q9_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  rec_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output rec_t pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      if (push && !pop) cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: design/d2q9_back.sv
// back part: per-direction relaxation pipeline and stream routing
`timescale 1ns / 1ps

module d2q9_back import d2q9_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      rec_valid_i,
  output logic      rec_ready_o,
  input  rec_t      rec_i,
  d2q9_res_if.source res_o
);

  localparam int NST = 7;

  typedef struct packed {
    logic [9:0]  dest_x;
    logic [9:0]  dest_y;
    logic [3:0]  dest_dir;
    logic        last;
    logic        solid;
    val_t        f;
    val_t        rho;
    val_t        vx;
    val_t        vy;
    logic [30:0] sq;
    val_t        cu;
    val_t        wr;
    val_t        uu;
    val_t        half;
    val_t        poly;
    val_t        eq;
    val_t        diff;
    val_t        m;
    val_t        val;
  } bp_t;

  rec_t       cur_q;
  logic       cur_v_q;
  logic [3:0] dir_q;
  logic       en, issue, pop;
  logic [NST-1:0] v_q;
  bp_t        st_q [NST];
  bp_t        nx   [NST];

  assign en          = !(v_q[NST-1] && !res_o.ready);
  assign issue       = en && cur_v_q;
  assign pop         = rec_valid_i && (!cur_v_q || (issue && dir_q == DIR_LAST));
  assign rec_ready_o = pop;

  always_comb begin
    logic signed [1:0]  cx, cy;
    logic signed [33:0] ax, ay;
    logic signed [11:0] tx, ty;
    logic signed [12:0] wl, hl;
    logic [32:0]        t3;
    logic               route;
    cx = dir_dx(dir_q);
    cy = dir_dy(dir_q);
    ax = (cx == 2'sd1) ? 34'(cur_q.vx) : (cx == -2'sd1) ? -34'(cur_q.vx) : '0;
    ay = (cy == 2'sd1) ? 34'(cur_q.vy) : (cy == -2'sd1) ? -34'(cur_q.vy) : '0;
    tx = $signed({2'b00, cur_q.base.x}) + 12'(cx);
    ty = $signed({2'b00, cur_q.base.y}) + 12'(cy);
    wl = $signed({2'b00, cfg_i.grid_w}) - 13'sd1;
    hl = $signed({2'b00, cfg_i.grid_h}) - 13'sd1;
    t3 = 33'(cur_q.sq) * 33'd3;
    route = !cur_q.base.mask[0] && !cur_q.base.mask[dir_q] &&
            tx > 12'sd0 && 13'(tx) < wl && ty > 12'sd0 && 13'(ty) < hl;

    nx[0]          = st_q[0];
    nx[0].f        = cur_q.base.f[dir_q];
    nx[0].solid    = cur_q.base.mask[0];
    nx[0].last     = dir_q == DIR_LAST;
    nx[0].dest_x   = route ? tx[9:0] : cur_q.base.x;
    nx[0].dest_y   = route ? ty[9:0] : cur_q.base.y;
    nx[0].dest_dir = route ? dir_q : dir_opp(dir_q);
    nx[0].rho      = cur_q.rho;
    nx[0].vx       = cur_q.vx;
    nx[0].vy       = cur_q.vy;
    nx[0].sq       = cur_q.sq;
    nx[0].cu       = sat32(40'(ax + ay) * 40'sd3);
    nx[0].wr       = mulq(weight(dir_q), cur_q.rho);
    nx[0].uu       = sat32($signed(40'(t3 >> 1)));

    nx[1]      = st_q[0];
    nx[1].half = mulq(st_q[0].cu, st_q[0].cu) >>> 1;

    nx[2]      = st_q[1];
    nx[2].poly = sat32(40'(ONE_Q) + 40'(st_q[1].cu) + 40'(st_q[1].half) - 40'(st_q[1].uu));

    nx[3]    = st_q[2];
    nx[3].eq = mulq(st_q[2].wr, st_q[2].poly);

    nx[4]      = st_q[3];
    nx[4].diff = sat32(40'(st_q[3].f) - 40'(st_q[3].eq));

    nx[5]   = st_q[4];
    nx[5].m = mulq(val_t'({2'b00, cfg_i.omega}), st_q[4].diff);

    nx[6]     = st_q[5];
    nx[6].val = st_q[5].solid ? st_q[5].f : sat32(40'(st_q[5].f) - 40'(st_q[5].m));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      dir_q   <= '0;
      v_q     <= '0;
    end else begin
      if (pop) begin
        cur_v_q <= 1'b1;
        dir_q   <= '0;
      end else if (issue) begin
        if (dir_q == DIR_LAST) cur_v_q <= 1'b0;
        dir_q <= dir_q + 4'd1;
      end
      if (en) v_q <= {v_q[NST-2:0], cur_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) cur_q <= rec_i;
    if (en) begin
      for (int i = 0; i < NST; i++) st_q[i] <= nx[i];
    end
  end

  always_comb begin
    res_o.valid           = v_q[NST-1];
    res_o.data.dest_x     = st_q[NST-1].dest_x;
    res_o.data.dest_y     = st_q[NST-1].dest_y;
    res_o.data.dest_dir   = st_q[NST-1].dest_dir;
    res_o.data.post_value = st_q[NST-1].val;
    res_o.data.density    = st_q[NST-1].rho;
    res_o.data.vel_x      = st_q[NST-1].vx;
    res_o.data.vel_y      = st_q[NST-1].vy;
    res_o.data.speed_sq   = st_q[NST-1].sq;
    res_o.data.last       = st_q[NST-1].last;
  end

endmodule

FILE: design/d2q9_collide_stream_cell.sv
// top level of the d2q9 collide and stream cell
//
// cell_i takes one beat per lattice cell: coordinates, solid mask and the
// nine distributions. res_o gives nine beats per cell, directions 0 to 8
// in order, with last set on the ninth. Each beat carries the destination
// cell and slot, the relaxed or reflected value and the cell's density,
// velocity and squared speed.
// cfg_we_i writes omega (index 0), grid width (1) or grid height (2) from
// cfg_wdata_i; the user must issue writes only while the block is idle, a
// rule the block itself does not enforce. Throughput is set both by the
// velocity divider, which starts a new cell only once the last is done (a
// load step, then 8 steps of 4 quotient bits), and by the back part
// issuing one direction per cycle while res_o does not stall.
// Reset empties all stages and the queue and loads the register defaults.
// When res_o stalls the back pipeline holds; the queue and front stages
// keep taking cells until they are full, then cell_i.ready drops.
`timescale 1ns / 1ps

module d2q9_collide_stream_cell import d2q9_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [29:0] cfg_wdata_i,
  d2q9_cell_if.sink   cell_i,
  d2q9_res_if.source  res_o
);

  logic [29:0] omega_q;
  logic [10:0] grid_w_q, grid_h_q;
  cfg_t        cfg;

  logic rec_f_valid, rec_f_ready, rec_b_valid, rec_b_ready;
  rec_t rec_f, rec_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q  <= 30'(ONE_L);
      grid_w_q <= 11'd1024;
      grid_h_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OMEGA:  omega_q  <= cfg_wdata_i;
        CFG_GRID_W: grid_w_q <= cfg_wdata_i[10:0];
        CFG_GRID_H: grid_h_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.omega  = omega_q;
    cfg.grid_w = (32'(grid_w_q) > 32'(MAX_GRID_DIM)) ? 11'(MAX_GRID_DIM) : grid_w_q;
    cfg.grid_h = (32'(grid_h_q) > 32'(MAX_GRID_DIM)) ? 11'(MAX_GRID_DIM) : grid_h_q;
  end

  d2q9_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_i),
    .rec_valid_o(rec_f_valid),
    .rec_ready_i(rec_f_ready),
    .rec_o      (rec_f)
  );

  d2q9_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(rec_f_valid),
    .push_ready_o(rec_f_ready),
    .push_data_i (rec_f),
    .pop_valid_o (rec_b_valid),
    .pop_ready_i (rec_b_ready),
    .pop_data_o  (rec_b)
  );

  d2q9_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .rec_valid_i(rec_b_valid),
    .rec_ready_o(rec_b_ready),
    .rec_i      (rec_b),
    .res_o      (res_o)
  );

endmodule

FILE: tb/d2q9_collide_stream_cell_test.sv
// testbench for the d2q9 collide and stream cell: random and directed cells against a predictor
`timescale 1ns / 1ps

module d2q9_collide_stream_cell_test;
  import d2q9_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [29:0] cfg_wdata_i;

  d2q9_cell_if cell_ch();
  d2q9_res_if  res_ch();

  d2q9_collide_stream_cell i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_i     (cell_ch),
    .res_o      (res_ch)
  );

  res_t        pending_beats[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 0;
  int          stall_left = 0;
  logic [29:0] omega_q = 30'd268435456;
  logic [10:0] width_q = 11'd1024;
  logic [10:0] height_q = 11'd1024;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 7);
    res_ch.ready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >>> FRAC_BITS;
    return sat_s32((p < 0) ? -m : m);
  endfunction

  function automatic longint fix_div(longint num, longint den);
    longint unsigned a, d, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = a / d;
    r = a % d;
    if (q > 64'd4294967296) q = 64'd4294967296;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > 64'd4294967296) q = 64'd4294967296;
    end
    return sat_s32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic int step_x(int q);
    case (q)
      1, 5, 8: return 1;
      3, 6, 7: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int step_y(int q);
    case (q)
      2, 5, 6: return 1;
      4, 7, 8: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int back_dir(int q);
    int tbl[9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    return tbl[q];
  endfunction

  function automatic longint lattice_weight(int q);
    longint unity;
    unity = longint'(1) << FRAC_BITS;
    if (q == 0) return (4 * unity + 4) / 9;
    if (q <= 4) return (unity + 4) / 9;
    return (unity + 18) / 36;
  endfunction

  // collide and stream one cell into its nine destination beats
  task automatic predict_cell(cell_t c);
    longint f[9];
    longint rho_sum, mx, my, rho, vx, vy, sq, w, h, unity;
    longint cu, uu, half, poly, eq, diff, val, tx, ty, dx, dy;
    int dd;
    bit solid;
    res_t r;
    f = '{c.dist_rest, c.dist_east, c.dist_north, c.dist_west, c.dist_south,
          c.dist_northeast, c.dist_northwest, c.dist_southwest, c.dist_southeast};
    unity = longint'(1) << FRAC_BITS;
    rho_sum = 0; mx = 0; my = 0; vx = 0; vy = 0; sq = 0;
    w = (longint'(width_q) > longint'(MAX_GRID_DIM)) ? longint'(MAX_GRID_DIM)
                                                     : longint'(width_q);
    h = (longint'(height_q) > longint'(MAX_GRID_DIM)) ? longint'(MAX_GRID_DIM)
                                                      : longint'(height_q);
    solid = c.solid_mask[0];
    for (int q = 0; q < 9; q++) begin
      rho_sum += f[q];
      mx += f[q] * step_x(q);
      my += f[q] * step_y(q);
    end
    if (solid) begin
      rho = sat_s32(unity);
    end else begin
      rho = sat_s32(rho_sum);
      if (rho_sum != 0) begin
        vx = fix_div(mx, rho_sum);
        vy = fix_div(my, rho_sum);
      end
      sq = sat_s32(fix_mul(vx, vx) + fix_mul(vy, vy));
    end
    for (int q = 0; q < 9; q++) begin
      dx = longint'(c.cell_x);
      dy = longint'(c.cell_y);
      dd = back_dir(q);
      if (solid) begin
        val = f[q];
      end else begin
        cu = sat_s32(3 * (step_x(q) * vx + step_y(q) * vy));
        uu = sat_s32((3 * sq) >>> 1);
        half = fix_mul(cu, cu) >>> 1;
        poly = sat_s32(unity + cu + half - uu);
        eq = fix_mul(fix_mul(lattice_weight(q), rho), poly);
        diff = sat_s32(f[q] - eq);
        val = sat_s32(f[q] - fix_mul(longint'(omega_q), diff));
        tx = dx + step_x(q);
        ty = dy + step_y(q);
        if (tx > 0 && tx < w - 1 && ty > 0 && ty < h - 1 && !c.solid_mask[q]) begin
          dx = tx;
          dy = ty;
          dd = q;
        end
      end
      r.dest_x = dx[9:0];
      r.dest_y = dy[9:0];
      r.dest_dir = dd[3:0];
      r.post_value = val[31:0];
      r.density = rho[31:0];
      r.vel_x = vx[31:0];
      r.vel_y = vy[31:0];
      r.speed_sq = sq[30:0];
      r.last = (q == 8);
      pending_beats.push_back(r);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e, a;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      a = res_ch.data;
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, a);
        fail_count++;
      end else begin
        e = pending_beats.pop_front();
        check_field("dest_x", longint'(e.dest_x), longint'(a.dest_x));
        check_field("dest_y", longint'(e.dest_y), longint'(a.dest_y));
        check_field("dest_dir", longint'(e.dest_dir), longint'(a.dest_dir));
        check_field("post_value", longint'(e.post_value), longint'(a.post_value));
        check_field("density", longint'(e.density), longint'(a.density));
        check_field("vel_x", longint'(e.vel_x), longint'(a.vel_x));
        check_field("vel_y", longint'(e.vel_y), longint'(a.vel_y));
        check_field("speed_sq", longint'(e.speed_sq), longint'(a.speed_sq));
        check_field("last", longint'(e.last), longint'(a.last));
      end
    end
  end

  task automatic send_cell(cell_t c);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      cell_ch.valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    cell_ch.valid <= 1;
    cell_ch.data <= c;
    @(posedge clk_i);
    while (!cell_ch.ready) @(posedge clk_i);
    predict_cell(c);
  endtask

  task automatic go_idle();
    cell_ch.valid <= 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [29:0] value);
    go_idle();
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      CFG_OMEGA:  omega_q = value;
      CFG_GRID_W: width_q = value[10:0];
      CFG_GRID_H: height_q = value[10:0];
      default: ;
    endcase
  endtask

  function automatic int pick_coord(int dim);
    int lim;
    lim = (dim > 1024 || dim < 2) ? 1024 : dim;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return lim - 2;
      3: return lim - 1;
      4: return $urandom_range(0, 1023);
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    val_t f[9];
    int kind;
    c.cell_x = 10'(pick_coord(int'(width_q)));
    c.cell_y = 10'(pick_coord(int'(height_q)));
    c.solid_mask = 9'($urandom_range(0, 511));
    if ($urandom_range(0, 3) != 0) c.solid_mask[0] = 0;
    kind = $urandom_range(0, 9);
    for (int q = 0; q < 9; q++) begin
      if (kind < 7)
        f[q] = val_t'(lattice_weight(q) + $signed($urandom_range(0, 8000000)) - 4000000);
      else if (kind < 9)
        f[q] = $urandom;
      else
        f[q] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    end
    {c.dist_rest, c.dist_east, c.dist_north, c.dist_west, c.dist_south,
     c.dist_northeast, c.dist_northwest, c.dist_southwest, c.dist_southeast} =
      {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]};
    return c;
  endfunction

  function automatic cell_t flat_cell(int x, int y, int mask, val_t v);
    cell_t c;
    c.cell_x = 10'(x);
    c.cell_y = 10'(y);
    c.solid_mask = 9'(mask);
    {c.dist_rest, c.dist_east, c.dist_north, c.dist_west, c.dist_south,
     c.dist_northeast, c.dist_northwest, c.dist_southwest, c.dist_southeast} = {9{v}};
    return c;
  endfunction

  task automatic test_directed();
    cell_t c;
    send_cell(flat_cell(5, 5, 0, val_t'(32'sd29826162)));
    send_cell(flat_cell(5, 5, 0, '0));
    send_cell(flat_cell(5, 5, 0, -val_t'(32'sd29826162)));
    send_cell(flat_cell(1023, 1023, 0, VAL_MAX));
    send_cell(flat_cell(0, 0, 0, VAL_MIN));
    send_cell(flat_cell(7, 9, 9'h001, VAL_MAX));
    send_cell(flat_cell(512, 3, 9'h1ff, val_t'(32'sd12345678)));
    send_cell(flat_cell(1, 1, 9'h1fe, ONE_Q));
    send_cell(flat_cell(1022, 1022, 0, ONE_Q));
    send_cell(flat_cell(1021, 1021, 0, ONE_Q));
    c = flat_cell(100, 100, 9'h0aa, ONE_Q);
    c.dist_east = VAL_MAX;
    c.dist_west = VAL_MIN;
    send_cell(c);
    c = flat_cell(200, 300, 0, '0);
    c.dist_rest = ONE_Q;
    c.dist_northeast = ONE_Q;
    c.dist_southwest = -ONE_Q;
    send_cell(c);
    c = flat_cell(2, 1000, 0, '0);
    c.dist_east = ONE_Q;
    c.dist_west = -ONE_Q;
    send_cell(c);
    c = flat_cell(300, 2, 0, 32'sd1);
    c.dist_north = -32'sd9;
    send_cell(c);
    write_reg(CFG_GRID_W, 30'd16);
    write_reg(CFG_GRID_H, 30'd8);
    send_cell(flat_cell(20, 4, 0, ONE_Q));
    send_cell(flat_cell(4, 7, 0, ONE_Q));
    send_cell(flat_cell(14, 6, 0, ONE_Q));
  endtask

  task automatic run_phase(logic [29:0] om, logic [10:0] gw, logic [10:0] gh, int n);
    write_reg(CFG_OMEGA, om);
    write_reg(CFG_GRID_W, 30'(gw));
    write_reg(CFG_GRID_H, 30'(gh));
    repeat (n) send_cell(random_cell());
  endtask

  task automatic test_register_sweep();
    run_phase(30'd268435456, 11'd1024, 11'd1024, 60);
    run_phase(30'd0, 11'd8, 11'd8, 50);
    run_phase(30'd536870912, 11'd2047, 11'd1024, 60);
    run_phase(30'h3fffffff, 11'd37, 11'd1500, 50);
    run_phase(30'($urandom_range(0, 536870912)), 11'($urandom_range(8, 1024)),
              11'($urandom_range(8, 1024)), 60);
    run_phase(30'd402653184, 11'd3, 11'd0, 20);
  endtask

  task automatic test_drain_pauses();
    run_phase(30'd322122547, 11'd64, 11'd48, 0);
    repeat (8) begin
      repeat ($urandom_range(1, 5)) send_cell(random_cell());
      go_idle();
    end
  endtask

  task automatic test_full_rate();
    write_reg(CFG_OMEGA, 30'd456340275);
    write_reg(CFG_GRID_W, 30'd1024);
    write_reg(CFG_GRID_H, 30'd512);
    quiet = 1;
    repeat (120) send_cell(random_cell());
  endtask

  initial begin
    cfg_we_i = 0;
    cfg_idx_i = CFG_OMEGA;
    cfg_wdata_i = '0;
    cell_ch.valid = 0;
    cell_ch.data = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_drain_pauses();
    test_full_rate();
    go_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
